FILE: hw/rtl/nmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nmr_pkg;

  localparam int RING_SLOTS = 64;
  localparam int CHANNELS   = 4096;
  localparam int RING_AW    = $clog2(RING_SLOTS);
  localparam int MAP_AW     = $clog2(CHANNELS);
  localparam int CHAN_W     = 16;
  localparam int STAT_W     = 3;
  localparam int OUT_W      = 24;
  localparam int PAD_W      = OUT_W - CHAN_W - STAT_W - 1;

  typedef enum logic [1:0] {
    KIND_SEND     = 2'd0,
    KIND_DRAIN    = 2'd1,
    KIND_REGISTER = 2'd2,
    KIND_DELETE   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_UNREGISTERED = 3'd1,
    STAT_INVALID      = 3'd2,
    STAT_FULL         = 3'd3,
    STAT_EMPTY        = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RING,
    ST_MAP,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/notification_mailbox_ring.sv
// Notification mailbox: a ring of pending channel ids plus a map of
// registered channels.
// Input channel s_*: one request per item, kind in s_tuser, channel id in
// s_tdata. Output channel m_*: result items; a non-empty drain returns one
// item per pending id with m_tlast on the final one, every other request one item.
// Send, register and delete results are valid in the cycle after
// acceptance. A drain of a non-empty ring handles each pending id in three
// steps, ring read, map read and output load, as the map read is addressed
// by the ring read result.
// After reset the registered map is cleared one entry per cycle, all
// CHANNELS (4096) entries, while s_tready stays low.
// A single output register holds each result; while it is full and not
// taken, s_tready stays low and a drain waits before loading its next item.
`timescale 1ns / 1ps
`default_nettype none
module notification_mailbox_ring
  import nmr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [CHAN_W-1:0] s_tdata,   // [15:0] channel_id
  input  wire logic [1:0]        s_tuser,   // [1:0] kind
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // [15:0] result_channel, [18:16] status,
                                            // [19] irq_pending, [23:20] zero
  output logic                   m_tlast
);

  state_t              state, state_next;
  logic [RING_AW-1:0]  rp, rp_next, wp, wp_next, rp_inc, wp_inc;
  logic                irq, irq_next;
  logic [MAP_AW-1:0]   clr, clr_next;

  logic                out_valid, out_valid_next;
  logic [CHAN_W-1:0]   out_chan, out_chan_next;
  status_t             out_status, out_status_next;
  logic                out_irq, out_irq_next;
  logic                out_last, out_last_next;

  logic [CHAN_W-1:0]   id, id_next;
  logic                id_ok, id_ok_next;

  logic [CHAN_W-1:0]   ring_mem [RING_SLOTS];
  logic                ring_we, ring_re;
  logic [CHAN_W-1:0]   ring_q;

  logic                map_mem [CHANNELS];
  logic                map_we, map_wd, map_re;
  logic [MAP_AW-1:0]   map_wa;
  logic                map_q;

  logic                out_free, chan_ok;
  kind_t               kind;

  assign rp_inc   = (rp == RING_AW'(RING_SLOTS - 1)) ? '0 : rp + RING_AW'(1);
  assign wp_inc   = (wp == RING_AW'(RING_SLOTS - 1)) ? '0 : wp + RING_AW'(1);
  assign out_free = !out_valid || m_tready;
  assign chan_ok  = s_tdata < CHAN_W'(CHANNELS);
  assign kind     = kind_t'(s_tuser);
  assign s_tready = (state == ST_IDLE) && out_free;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_irq, out_status, out_chan};
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp] <= s_tdata;
    end
    if (ring_re) begin
      ring_q <= ring_mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_q <= map_mem[ring_q[MAP_AW-1:0]];
    end
  end

  always_comb begin
    state_next      = state;
    rp_next         = rp;
    wp_next         = wp;
    irq_next        = irq;
    clr_next        = clr;
    out_valid_next  = out_valid && !m_tready;
    out_chan_next   = out_chan;
    out_status_next = out_status;
    out_irq_next    = out_irq;
    out_last_next   = out_last;
    id_next         = id;
    id_ok_next      = id_ok;
    ring_we         = 1'b0;
    ring_re         = 1'b0;
    map_we          = 1'b0;
    map_wd          = 1'b0;
    map_wa          = s_tdata[MAP_AW-1:0];
    map_re          = 1'b0;
    case (state)
      ST_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr;
        if (clr == MAP_AW'(CHANNELS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_next = clr + MAP_AW'(1);
        end
      end
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          out_chan_next = s_tdata;
          out_irq_next  = irq;
          out_last_next = 1'b1;
          case (kind)
            KIND_SEND: begin
              out_valid_next = 1'b1;
              if (!chan_ok) begin
                out_status_next = STAT_INVALID;
              end else if (wp_inc == rp) begin
                out_status_next = STAT_FULL;
              end else begin
                ring_we         = 1'b1;
                wp_next         = wp_inc;
                irq_next        = 1'b1;
                out_irq_next    = 1'b1;
                out_status_next = STAT_OK;
              end
            end
            KIND_DRAIN: begin
              if (rp == wp) begin
                out_valid_next  = 1'b1;
                out_chan_next   = '0;
                out_status_next = STAT_EMPTY;
              end else begin
                irq_next   = 1'b0;
                state_next = ST_RING;
              end
            end
            default: begin
              out_valid_next = 1'b1;
              if (!chan_ok) begin
                out_status_next = STAT_INVALID;
              end else begin
                map_we          = 1'b1;
                map_wd          = (kind == KIND_REGISTER);
                out_status_next = STAT_OK;
              end
            end
          endcase
        end
      end
      ST_RING: begin
        ring_re    = 1'b1;
        state_next = ST_MAP;
      end
      ST_MAP: begin
        map_re     = 1'b1;
        id_next    = ring_q;
        id_ok_next = ring_q < CHAN_W'(CHANNELS);
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_chan_next   = id;
          out_status_next = (id_ok && map_q) ? STAT_OK : STAT_UNREGISTERED;
          out_irq_next    = 1'b0;
          out_last_next   = (rp_inc == wp);
          rp_next         = rp_inc;
          state_next      = (rp_inc == wp) ? ST_IDLE : ST_RING;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rp        <= '0;
      wp        <= '0;
      irq       <= 1'b0;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rp        <= rp_next;
      wp        <= wp_next;
      irq       <= irq_next;
      clr       <= clr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_chan   <= out_chan_next;
    out_status <= out_status_next;
    out_irq    <= out_irq_next;
    out_last   <= out_last_next;
    id         <= id_next;
    id_ok      <= id_ok_next;
  end

endmodule
`default_nettype wire
